### rtl/cll_pkg.sv
package cll_pkg;

  localparam int CAPACITY   = 32;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    OP_ADD_FRONT,
    OP_ADD_AFTER,
    OP_ADD_BACK,
    OP_DEL_FRONT,
    OP_DEL_BACK,
    OP_DEL_KEY
  } op_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_EMPTY,
    ST_NOTFOUND,
    ST_FULL
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_INS_A,
    S_INS_B,
    S_INS_C,
    S_DEL_RD,
    S_WALK,
    S_DEL_LINK,
    S_DEL_FREE
  } state_e;

  typedef enum logic [1:0] {
    DK_HEAD,
    DK_TAIL,
    DK_MID
  } del_kind_e;

  typedef struct packed {
    logic [IDX_W-1:0]      raddr;
    logic                  val_we;
    logic [IDX_W-1:0]      val_waddr;
    logic [DATA_WIDTH-1:0] val_wdata;
    logic                  nxt_we;
    logic [IDX_W-1:0]      nxt_waddr;
    logic [IDX_W-1:0]      nxt_wdata;
  } mem_req_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] value;
    logic [IDX_W-1:0]      next;
  } mem_rsp_t;

  // free list chain after reset: i points at i+1, last wraps to 0
  function automatic logic [IDX_W-1:0] next_init(input logic [IDX_W-1:0] i);
    logic [IDX_W:0] inc;
    inc = {1'b0, i} + (IDX_W+1)'(1);
    return (inc == (IDX_W+1)'(CAPACITY)) ? '0 : inc[IDX_W-1:0];
  endfunction

  // store the low data bits of the sign-extended input
  function automatic logic [DATA_WIDTH-1:0] to_data(input logic [31:0] v);
    logic signed [31:0] sv;
    sv = signed'(v);
    return DATA_WIDTH'(sv);
  endfunction

  // stored value sign-extended, low 32 bits
  function automatic logic [31:0] out_val(input logic [DATA_WIDTH-1:0] d);
    logic signed [DATA_WIDTH-1:0] sd;
    sd = signed'(d);
    return 32'(sd);
  endfunction

endpackage

### rtl/cll_node_mem.sv
module cll_node_mem
  import cll_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output mem_rsp_t rsp_o
);

  logic [DATA_WIDTH-1:0] val_mem [CAPACITY];
  logic [IDX_W-1:0]      nxt_mem [CAPACITY];
  logic [CAPACITY-1:0]   nxt_vld_q;

  logic [DATA_WIDTH-1:0] val_rd_q;
  logic [IDX_W-1:0]      nxt_rd_q;
  logic                  vld_rd_q;
  logic [IDX_W-1:0]      raddr_q;

  // next entries not yet written read as the reset free chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nxt_vld_q <= '0;
    end else if (req_i.nxt_we) begin
      nxt_vld_q[req_i.nxt_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.val_we) begin
      val_mem[req_i.val_waddr] <= req_i.val_wdata;
    end
    if (req_i.nxt_we) begin
      nxt_mem[req_i.nxt_waddr] <= req_i.nxt_wdata;
    end
    val_rd_q <= val_mem[req_i.raddr];
    nxt_rd_q <= nxt_mem[req_i.raddr];
    vld_rd_q <= nxt_vld_q[req_i.raddr];
    raddr_q  <= req_i.raddr;
  end

  assign rsp_o.value = val_rd_q;
  assign rsp_o.next  = vld_rd_q ? nxt_rd_q : next_init(raddr_q);

endmodule

### rtl/cll_ctrl.sv
module cll_ctrl
  import cll_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op_i,
  input  logic [31:0] value_i,
  input  logic [31:0] key_i,
  output mem_req_t    req_o,
  input  mem_rsp_t    rsp_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] removed_value_o,
  output logic [5:0]  count_o
);

  state_e                st_q, st_d;
  op_e                   op_q, op_d;
  del_kind_e             kind_q, kind_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [DATA_WIDTH-1:0] key_q, key_d;
  logic [DATA_WIDTH-1:0] rm_q, rm_d;
  logic [IDX_W-1:0]      p_q, p_d;
  logic [IDX_W-1:0]      q_q, q_d;
  logic [IDX_W-1:0]      n_q, n_d;
  logic [IDX_W-1:0]      link_q, link_d;
  logic [IDX_W-1:0]      pred_q, pred_d;
  logic [CNT_W-1:0]      rem_q, rem_d;
  logic [IDX_W-1:0]      head_q, head_d;
  logic [IDX_W-1:0]      tail_q, tail_d;
  logic [IDX_W-1:0]      free_q, free_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  done_q, done_d;
  status_e               status_q, status_d;
  logic [31:0]           removed_q, removed_d;

  logic full, empty, multi;

  assign full  = (count_q >= CNT_W'(CAPACITY));
  assign empty = (count_q == '0);
  assign multi = (count_q > CNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      free_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      st_q    <= st_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      free_q  <= free_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    kind_q    <= kind_d;
    val_q     <= val_d;
    key_q     <= key_d;
    rm_q      <= rm_d;
    p_q       <= p_d;
    q_q       <= q_d;
    n_q       <= n_d;
    link_q    <= link_d;
    pred_q    <= pred_d;
    rem_q     <= rem_d;
    status_q  <= status_d;
    removed_q <= removed_d;
  end

  always_comb begin
    st_d      = st_q;
    op_d      = op_q;
    kind_d    = kind_q;
    val_d     = val_q;
    key_d     = key_q;
    rm_d      = rm_q;
    p_d       = p_q;
    q_d       = q_q;
    n_d       = n_q;
    link_d    = link_q;
    pred_d    = pred_q;
    rem_d     = rem_q;
    head_d    = head_q;
    tail_d    = tail_q;
    free_d    = free_q;
    count_d   = count_q;
    done_d    = 1'b0;
    status_d  = status_q;
    removed_d = removed_q;
    req_o     = '0;

    unique case (st_q)
      S_IDLE: begin
        if (start) begin
          op_d      = op_e'(op_i);
          val_d     = to_data(value_i);
          key_d     = to_data(key_i);
          status_d  = ST_OK;
          removed_d = '0;
          unique case (op_i)
            OP_ADD_FRONT, OP_ADD_BACK: begin
              if (full) begin
                status_d = ST_FULL;
                done_d   = 1'b1;
              end else begin
                link_d = empty ? free_q : head_q;
                pred_d = tail_q;
                st_d   = S_INS_A;
              end
            end
            OP_ADD_AFTER, OP_DEL_KEY: begin
              if (empty) begin
                status_d = ST_EMPTY;
                done_d   = 1'b1;
              end else if (full && op_i == OP_ADD_AFTER) begin
                status_d = ST_FULL;
                done_d   = 1'b1;
              end else begin
                req_o.raddr = head_q;
                p_d         = head_q;
                q_d         = tail_q;
                rem_d       = count_q - CNT_W'(1);
                st_d        = S_FIND;
              end
            end
            OP_DEL_FRONT: begin
              if (empty) begin
                status_d = ST_EMPTY;
                done_d   = 1'b1;
              end else begin
                req_o.raddr = head_q;
                n_d         = head_q;
                pred_d      = tail_q;
                kind_d      = DK_HEAD;
                st_d        = S_DEL_RD;
              end
            end
            OP_DEL_BACK: begin
              if (empty) begin
                status_d = ST_EMPTY;
                done_d   = 1'b1;
              end else begin
                req_o.raddr = tail_q;
                n_d         = tail_q;
                kind_d      = DK_TAIL;
                st_d        = S_DEL_RD;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // data for node p is on the read port
      S_FIND: begin
        if (rsp_i.value == key_q) begin
          if (op_q == OP_ADD_AFTER) begin
            pred_d = p_q;
            link_d = rsp_i.next;
            st_d   = S_INS_A;
          end else if (p_q == head_q) begin
            req_o.raddr = p_q;
            n_d         = p_q;
            pred_d      = tail_q;
            kind_d      = DK_HEAD;
            st_d        = S_DEL_RD;
          end else if (p_q == tail_q) begin
            req_o.raddr = tail_q;
            n_d         = tail_q;
            kind_d      = DK_TAIL;
            st_d        = S_DEL_RD;
          end else begin
            rm_d   = rsp_i.value;
            n_d    = p_q;
            pred_d = q_q;
            link_d = rsp_i.next;
            kind_d = DK_MID;
            st_d   = S_DEL_LINK;
          end
        end else if (rem_q == '0) begin
          status_d = ST_NOTFOUND;
          done_d   = 1'b1;
          st_d     = S_IDLE;
        end else begin
          req_o.raddr = rsp_i.next;
          q_d         = p_q;
          p_d         = rsp_i.next;
          rem_d       = rem_q - CNT_W'(1);
        end
      end

      // take the free head, fetch its successor on the free list
      S_INS_A: begin
        req_o.raddr     = free_q;
        req_o.val_we    = 1'b1;
        req_o.val_waddr = free_q;
        req_o.val_wdata = val_q;
        n_d             = free_q;
        st_d            = S_INS_B;
      end

      S_INS_B: begin
        free_d          = rsp_i.next;
        req_o.nxt_we    = 1'b1;
        req_o.nxt_waddr = n_q;
        req_o.nxt_wdata = link_q;
        if (empty) begin
          head_d   = n_q;
          tail_d   = n_q;
          count_d  = count_q + CNT_W'(1);
          done_d   = 1'b1;
          st_d     = S_IDLE;
        end else begin
          st_d = S_INS_C;
        end
      end

      S_INS_C: begin
        req_o.nxt_we    = 1'b1;
        req_o.nxt_waddr = pred_q;
        req_o.nxt_wdata = n_q;
        if (op_q == OP_ADD_FRONT) begin
          head_d = n_q;
        end else if (op_q == OP_ADD_BACK || pred_q == tail_q) begin
          tail_d = n_q;
        end
        count_d = count_q + CNT_W'(1);
        done_d  = 1'b1;
        st_d    = S_IDLE;
      end

      // victim value and successor are on the read port
      S_DEL_RD: begin
        rm_d = rsp_i.value;
        if (!multi) begin
          st_d = S_DEL_FREE;
        end else if (kind_q == DK_HEAD) begin
          head_d = rsp_i.next;
          link_d = rsp_i.next;
          st_d   = S_DEL_LINK;
        end else begin
          // predecessor of the tail sits count-2 hops from the head
          link_d = head_q;
          if (count_q == CNT_W'(2)) begin
            pred_d = head_q;
            st_d   = S_DEL_LINK;
          end else begin
            req_o.raddr = head_q;
            rem_d       = count_q - CNT_W'(3);
            st_d        = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (rem_q == '0) begin
          pred_d = rsp_i.next;
          st_d   = S_DEL_LINK;
        end else begin
          req_o.raddr = rsp_i.next;
          rem_d       = rem_q - CNT_W'(1);
        end
      end

      S_DEL_LINK: begin
        req_o.nxt_we    = 1'b1;
        req_o.nxt_waddr = pred_q;
        req_o.nxt_wdata = link_q;
        if (kind_q == DK_TAIL) begin
          tail_d = pred_q;
        end
        st_d = S_DEL_FREE;
      end

      S_DEL_FREE: begin
        req_o.nxt_we    = 1'b1;
        req_o.nxt_waddr = n_q;
        req_o.nxt_wdata = free_q;
        free_d          = n_q;
        count_d         = count_q - CNT_W'(1);
        removed_d       = out_val(rm_q);
        done_d          = 1'b1;
        st_d            = S_IDLE;
      end

      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  assign busy            = (st_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign count_o         = 6'(count_q);

endmodule

### rtl/circular_linked_list_engine.sv
// circular singly linked list engine with a free list of spare nodes
//
// command channel: an operation is taken at a rising edge with start high
// and busy low; op_i, value_i and key_i are sampled at that edge only.
// result channel: done_o is high for exactly one cycle, with status_o,
// removed_value_o and count_o valid in that cycle; the receiver cannot
// hold results off, one result per command.
// steps from the accepting edge to the done cycle:
//   full, empty, unknown op: done straight from idle, busy stays low
//   add front / add back: take a free node, link it, relink its predecessor
//   delete front: read the victim, relink, free; delete back may also walk
//   to the tail's predecessor; add after key / delete key: search node by
//   node, then insert or unlink as above, or end with not found
// the key search and the tail predecessor walk each read one node per
// cycle from the single read port of the node memories; busy drops in
// the done cycle and the next command may be issued there.
// reset: empty list, all nodes on the free list; next pointers come out
// of reset through per-entry valid bits, so there is no clearing pass.
module circular_linked_list_engine
  import cll_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op_i,
  input  logic [31:0] value_i,
  input  logic [31:0] key_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] removed_value_o,
  output logic [5:0]  count_o
);

  // memory request from the sequencer, registered read data back
  mem_req_t mem_req;
  mem_rsp_t mem_rsp;

  // sequencer: holds head, tail, free head and count, walks the list
  cll_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .op_i            (op_i),
    .value_i         (value_i),
    .key_i           (key_i),
    .req_o           (mem_req),
    .rsp_i           (mem_rsp),
    .done_o          (done_o),
    .status_o        (status_o),
    .removed_value_o (removed_value_o),
    .count_o         (count_o)
  );

  // node value and next pointer memories, one read address per cycle
  cll_node_mem u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .rsp_o  (mem_rsp)
  );

endmodule
